>>> rtl/core/frame_interval_rate_meter_defines.svh
// Assertion macros shared by the frame interval rate meter RTL.
`ifndef FRAME_INTERVAL_RATE_METER_DEFINES_SVH
`define FRAME_INTERVAL_RATE_METER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define FIRM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame interval rate meter: property violated");
// Check that the consequent holds in the cycle after the antecedent.
`define FIRM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame interval rate meter: property violated");
`else
`define FIRM_ASSERT_NOW(lbl, ante, cons)
`define FIRM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/firm_pkg.sv
// Shared types and constants of the frame interval rate meter.
`default_nettype none
package firm_pkg;

	localparam int WORD_W     = 32;
	localparam int SUM_W      = 48;
	localparam int LW_W       = 16;
	localparam int GUESS_W    = 10;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int HIST_DEPTH = 5;
	localparam int RATE_FRAC  = 8;

	// 1000 = 1024 - 16 - 8: product taps of the serial constant multiplier
	localparam int MULT_W = 10;
	localparam int TAP_HI = 10;
	localparam int TAP_A  = 4;
	localparam int TAP_B  = 3;
	localparam int PROD_W = WORD_W + MULT_W;

	// divider: dividend is frames * 1000 * 2^RATE_FRAC, divisor is 33-bit elapsed time
	localparam int DVD_W  = PROD_W + RATE_FRAC;
	localparam int DIV_W  = WORD_W + 1;
	localparam int DCNT_W = $clog2(DVD_W);
	localparam logic [DCNT_W-1:0] DVD_LAST = DCNT_W'(DVD_W - 1);

	// serial pass counter
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] CMP_LAST   = CNT_W'(WORD_W - 1);
	localparam logic [CNT_W-1:0] WORD_BITS  = CNT_W'(WORD_W);
	localparam logic [CNT_W-1:0] PROD_BITS  = CNT_W'(PROD_W);
	localparam logic [CNT_W-1:0] PROD_LAST  = CNT_W'(PROD_W - 1);
	localparam logic [CNT_W-1:0] SER_LAST   = CNT_W'(SUM_W - 1);

	localparam logic [LW_W-1:0]    LW_RESET    = 16'd500;
	localparam logic [GUESS_W-1:0] GUESS_RESET = 10'd30;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_MARK  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LONG_WINDOW = 1'b0,
		CFG_START_GUESS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SER,
		ST_DIV,
		ST_DONE
	} firm_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/firm_chan_if.sv
// Valid/ready channel interfaces for meter events and results.
`default_nettype none
interface firm_in_if import firm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [WORD_W-1:0] clock_ms;

	modport source (output valid, output action, output clock_ms, input ready);
	modport sink (input valid, input action, input clock_ms, output ready);
endinterface

interface firm_out_if import firm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] frame_time_ms;
	logic [WORD_W-1:0] window_span_ms;
	logic [SUM_W-1:0]  span_sum;
	logic [WORD_W-1:0] frame_count;
	logic [WORD_W-1:0] long_rate_q8;
	logic              rate_updated;
	logic              time_held;

	modport source (output valid, output frame_time_ms, output window_span_ms,
		output span_sum, output frame_count, output long_rate_q8,
		output rate_updated, output time_held, input ready);
	modport sink (input valid, input frame_time_ms, input window_span_ms,
		input span_sum, input frame_count, input long_rate_q8,
		input rate_updated, input time_held, output ready);
endinterface
`default_nettype wire

>>> rtl/core/firm_div.sv
// Radix-2 restoring divider with saturating 32-bit quotient.
`default_nettype none
module firm_div import firm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DVD_W-1:0]  dividend,
	input  wire logic [DIV_W-1:0]  divisor,
	output div_stat_t              stat,
	output logic [WORD_W-1:0]      quotient
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [DIV_W-1:0]  rem_q;
	logic [WORD_W-1:0] quo_q;
	logic              ovf_q;

	logic [DIV_W:0]    trial;
	logic [DIV_W+1:0]  diff;
	logic              ge;

	// one quotient bit per cycle, dividend fed MSB first
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};
	assign ge    = !diff[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DVD_LAST;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], ge};
			// any bit pushed out above 32 bits saturates the result
			ovf_q <= ovf_q | quo_q[WORD_W-1];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = ovf_q ? '1 : quo_q;

endmodule
`default_nettype wire

>>> rtl/core/frame_interval_rate_meter.sv
// Top level of the frame interval rate meter: bit-serial timing datapath and control.
//
// Channel  | Role   | Payload / signals
// ---------+--------+-------------------------------------------------------------
// events   | sink   | action (0 start, 1 frame mark), clock_ms
// results  | source | frame_time_ms, window_span_ms, span_sum, frame_count,
//          |        | long_rate_q8, rate_updated, time_held
// config   | write  | cfg_wr_en, cfg_index (0 long_window_ms, 1 start_interval_guess_ms),
//          |        | cfg_data
//
// Sequence: each transaction runs a 32-bit serial compare against the latest reading, then
// a serial pass over the 48-bit span sum, and the 50-step divider when the mark closes a
// rate window, before the block is ready for the next event.
// Reset: asynchronous, active low; all timing state clears at once, no sweep.
// Stalls: the result sits in an output register; the next event is taken while it waits,
// and the block holds its finished work until the result register is free.
`default_nettype none
`include "frame_interval_rate_meter_defines.svh"
module frame_interval_rate_meter import firm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	firm_in_if.sink                   events,
	firm_out_if.source                results,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// ---------------------------------------------------------------- control
	firm_state_t      state_q, state_nx;
	logic [CNT_W-1:0] bit_q;
	logic             in_ready, cmp_en, ser_en, div_go, out_load;
	logic             lo, prod_en, ser_last, accept;

	// ---------------------------------------------------------------- configuration
	logic [LW_W-1:0]    long_window_q;
	logic [GUESS_W-1:0] guess_q;

	// ---------------------------------------------------------------- timing state
	logic [WORD_W-1:0] latest_q, last_mark_q, total_q, wframes_q, deadline_q, rate_q;
	logic [WORD_W-1:0] hist_q [HIST_DEPTH];
	logic [SUM_W-1:0]  span_total_q;

	// ---------------------------------------------------------------- per-transaction
	logic               action_q, updated_q;
	logic [WORD_W-1:0]  raw_q, ft_q, span_q, elapsed_q, new_deadline_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LW_W-1:0]    lw_sr_q;
	logic [GUESS_W-1:0] guess_sr_q;
	logic [TAP_HI-1:0]  wtap_q;
	// serial carries and borrows
	logic lt_q, ft_br_q, sp_br_q, st_c_q, tf_c_q, wf_c_q, gt_q, d_br_q, e_c_q, nd_c_q;
	logic [1:0]            p_br_q;
	logic [HIST_DEPTH-1:0] seed_br_q;

	// ---------------------------------------------------------------- result register
	logic              out_valid_q;
	logic [WORD_W-1:0] res_ft_q, res_span_q, res_count_q, res_rate_q;
	logic [SUM_W-1:0]  res_sum_q;
	logic              res_updated_q, res_held_q;

	// ---------------------------------------------------------------- divider
	div_stat_t         div_stat;
	logic [WORD_W-1:0] div_quot;

	// ---------------------------------------------------------------- serial bit logic
	logic tb, lmb, dlb, lwb, gb, ob;
	logic lt_n;
	logic ft_bit, ft_br_n, sp_bit, sp_br_n, sp_add, st_bit, st_c_n;
	logic tf_bit, tf_c_n, wf_bit, wf_c_n, w_bit;
	logic gt_n, d_bit, d_br_n, e_bit, e_c_n, nd_bit, nd_c_n;
	logic [2:0] px;
	logic       p_bit;
	logic [1:0] p_br_n;
	logic [HIST_DEPTH-1:0] seed_bit, seed_br_n, hist_in;

	assign accept   = in_ready && events.valid;
	assign lo       = bit_q < WORD_BITS;
	assign prod_en  = bit_q < PROD_BITS;
	assign ser_last = bit_q == SER_LAST;

	// control outputs per state
	always_comb begin
		in_ready = 1'b0;
		cmp_en   = 1'b0;
		ser_en   = 1'b0;
		div_go   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_CMP: begin
				cmp_en = 1'b1;
			end
			ST_SER: begin
				ser_en = 1'b1;
				// a mark past the deadline refreshes the rate
				div_go = ser_last && (action_q == ACT_MARK) && gt_q;
			end
			ST_DONE: begin
				out_load = !out_valid_q || results.ready;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (events.valid) state_nx = ST_CMP;
			end
			ST_CMP: begin
				if (bit_q == CMP_LAST) state_nx = ST_SER;
			end
			ST_SER: begin
				if (ser_last) state_nx = div_go ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (div_stat.done) state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Bit streams, LSB first. During the compare pass raw and latest rotate;
	// during the main pass every timing register streams one bit per cycle.
	assign tb  = lt_q ? latest_q[0] : raw_q[0];
	assign lmb = last_mark_q[0];
	assign dlb = deadline_q[0];
	assign lwb = lw_sr_q[0];
	assign gb  = guess_sr_q[0];
	assign ob  = hist_q[1][0];

	// raw reading below latest: replace it
	assign lt_n = (!raw_q[0] & latest_q[0]) | (!(raw_q[0] ^ latest_q[0]) & lt_q);

	// frame interval and five-frame span
	assign ft_bit  = tb ^ lmb ^ ft_br_q;
	assign ft_br_n = (!tb & lmb) | (!(tb ^ lmb) & ft_br_q);
	assign sp_bit  = tb ^ ob ^ sp_br_q;
	assign sp_br_n = (!tb & ob) | (!(tb ^ ob) & sp_br_q);

	// running span sum over 48 bits
	assign sp_add = lo & sp_bit;
	assign st_bit = span_total_q[0] ^ sp_add ^ st_c_q;
	assign st_c_n = (span_total_q[0] & sp_add) | (span_total_q[0] & st_c_q) |
		(sp_add & st_c_q);

	// frame counters increment
	assign tf_bit = total_q[0] ^ tf_c_q;
	assign tf_c_n = total_q[0] & tf_c_q;
	assign wf_bit = wframes_q[0] ^ wf_c_q;
	assign wf_c_n = wframes_q[0] & wf_c_q;

	// deadline compare, elapsed time and next deadline
	assign gt_n   = (tb & !dlb) | (!(tb ^ dlb) & gt_q);
	assign d_bit  = tb ^ dlb ^ d_br_q;
	assign d_br_n = (!tb & dlb) | (!(tb ^ dlb) & d_br_q);
	assign e_bit  = d_bit ^ lwb ^ e_c_q;
	assign e_c_n  = (d_bit & lwb) | (d_bit & e_c_q) | (lwb & e_c_q);
	assign nd_bit = tb ^ lwb ^ nd_c_q;
	assign nd_c_n = (tb & lwb) | (tb & nd_c_q) | (lwb & nd_c_q);

	// frames * 1000 as (w << 10) - (w << 4) - (w << 3), one bit a cycle
	assign w_bit  = lo & wf_bit;
	assign px     = 3'd4 + {2'b00, wtap_q[TAP_HI-1]} - {2'b00, wtap_q[TAP_A-1]} -
		{2'b00, wtap_q[TAP_B-1]} - {1'b0, p_br_q};
	assign p_bit  = px[0];
	assign p_br_n = 2'd2 - px[2:1];

	// start seeds history with t - guess, t - 2*guess, ... down the chain
	always_comb begin
		logic x;
		x = tb;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			seed_bit[HIST_DEPTH-1-k] = x ^ gb ^ seed_br_q[k];
			seed_br_n[k] = (!x & gb) | (!(x ^ gb) & seed_br_q[k]);
			x = seed_bit[HIST_DEPTH-1-k];
		end
	end

	// a mark moves the history down one place, old last mark enters at the top
	always_comb begin
		for (int k = 0; k < HIST_DEPTH - 1; k++) begin
			hist_in[k] = hist_q[k+1][0];
		end
		hist_in[HIST_DEPTH-1] = lmb;
	end

	// control registers, configuration and timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bit_q         <= '0;
			out_valid_q   <= 1'b0;
			long_window_q <= LW_RESET;
			guess_q       <= GUESS_RESET;
			latest_q      <= '0;
			last_mark_q   <= '0;
			total_q       <= '0;
			wframes_q     <= '0;
			deadline_q    <= '0;
			rate_q        <= '0;
			span_total_q  <= '0;
			for (int k = 0; k < HIST_DEPTH; k++) begin
				hist_q[k] <= '0;
			end
		end else begin
			state_q <= state_nx;

			if (accept) begin
				bit_q <= '0;
			end else if (cmp_en) begin
				bit_q <= (bit_q == CMP_LAST) ? '0 : bit_q + 1'b1;
			end else if (ser_en) begin
				bit_q <= bit_q + 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					CFG_LONG_WINDOW: long_window_q <= cfg_data[LW_W-1:0];
					CFG_START_GUESS: guess_q <= cfg_data[GUESS_W-1:0];
					default: begin
					end
				endcase
			end

			// rotate latest past the compare so it is back in place for the main pass
			if (cmp_en) begin
				latest_q <= {latest_q[0], latest_q[WORD_W-1:1]};
			end

			if (ser_en) begin
				if (lo) begin
					latest_q    <= {tb, latest_q[WORD_W-1:1]};
					last_mark_q <= {tb, last_mark_q[WORD_W-1:1]};
					deadline_q  <= {dlb, deadline_q[WORD_W-1:1]};
					if (action_q == ACT_START) begin
						total_q   <= {1'b0, total_q[WORD_W-1:1]};
						wframes_q <= {1'b0, wframes_q[WORD_W-1:1]};
						for (int k = 0; k < HIST_DEPTH; k++) begin
							hist_q[k] <= {seed_bit[k], hist_q[k][WORD_W-1:1]};
						end
					end else begin
						total_q   <= {tf_bit, total_q[WORD_W-1:1]};
						wframes_q <= {wf_bit, wframes_q[WORD_W-1:1]};
						for (int k = 0; k < HIST_DEPTH; k++) begin
							hist_q[k] <= {hist_in[k], hist_q[k][WORD_W-1:1]};
						end
					end
				end

				// clear on start, saturate on carry out of the top bit
				if (action_q == ACT_START) begin
					span_total_q <= '0;
				end else if (ser_last && st_c_n) begin
					span_total_q <= '1;
				end else begin
					span_total_q <= {st_bit, span_total_q[SUM_W-1:1]};
				end

				if (ser_last) begin
					if (action_q == ACT_START) begin
						deadline_q <= new_deadline_q;
						rate_q     <= '0;
					end else if (gt_q) begin
						deadline_q <= new_deadline_q;
						wframes_q  <= '0;
					end
				end
			end

			if (div_stat.done) begin
				rate_q <= div_quot;
			end
		end
	end

	// per-transaction shift registers and carries
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q   <= events.action;
			raw_q      <= events.clock_ms;
			lw_sr_q    <= long_window_q;
			guess_sr_q <= guess_q;
			lt_q       <= 1'b0;
			ft_br_q    <= 1'b0;
			sp_br_q    <= 1'b0;
			st_c_q     <= 1'b0;
			tf_c_q     <= 1'b1;
			wf_c_q     <= 1'b1;
			gt_q       <= 1'b0;
			d_br_q     <= 1'b0;
			e_c_q      <= 1'b0;
			nd_c_q     <= 1'b0;
			p_br_q     <= 2'd0;
			wtap_q     <= '0;
			seed_br_q  <= '0;
		end

		if (cmp_en) begin
			raw_q <= {raw_q[0], raw_q[WORD_W-1:1]};
			lt_q  <= lt_n;
		end

		if (ser_en) begin
			if (lo) begin
				raw_q          <= {tb, raw_q[WORD_W-1:1]};
				lw_sr_q        <= {1'b0, lw_sr_q[LW_W-1:1]};
				guess_sr_q     <= {1'b0, guess_sr_q[GUESS_W-1:1]};
				ft_q           <= {ft_bit & action_q, ft_q[WORD_W-1:1]};
				span_q         <= {sp_bit & action_q, span_q[WORD_W-1:1]};
				elapsed_q      <= {e_bit, elapsed_q[WORD_W-1:1]};
				new_deadline_q <= {nd_bit, new_deadline_q[WORD_W-1:1]};
				ft_br_q        <= ft_br_n;
				sp_br_q        <= sp_br_n;
				tf_c_q         <= tf_c_n;
				wf_c_q         <= wf_c_n;
				gt_q           <= gt_n;
				d_br_q         <= d_br_n;
				e_c_q          <= e_c_n;
				nd_c_q         <= nd_c_n;
				seed_br_q      <= seed_br_n;
			end
			if (prod_en) begin
				prod_q <= {p_bit, prod_q[PROD_W-1:1]};
				p_br_q <= p_br_n;
			end
			wtap_q <= {wtap_q[TAP_HI-2:0], w_bit};
			st_c_q <= st_c_n;
			if (ser_last) begin
				updated_q <= (action_q == ACT_MARK) && gt_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_ft_q      <= ft_q;
			res_span_q    <= span_q;
			res_sum_q     <= span_total_q;
			res_count_q   <= total_q;
			res_rate_q    <= rate_q;
			res_updated_q <= updated_q;
			res_held_q    <= lt_q;
		end
	end

	// rate = frames * 1000 * 2^RATE_FRAC / elapsed, elapsed is 33 bits
	firm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend ({prod_q, {RATE_FRAC{1'b0}}}),
		.divisor  ({e_c_q, elapsed_q}),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	assign events.ready           = in_ready;
	assign results.valid          = out_valid_q;
	assign results.frame_time_ms  = res_ft_q;
	assign results.window_span_ms = res_span_q;
	assign results.span_sum       = res_sum_q;
	assign results.frame_count    = res_count_q;
	assign results.long_rate_q8   = res_rate_q;
	assign results.rate_updated   = res_updated_q;
	assign results.time_held      = res_held_q;

	// divider runs only while the sequencer waits for it
	`FIRM_ASSERT_NOW(a_div_busy_in_div, div_stat.busy, state_q == ST_DIV)
	// the product of a 32-bit count and 1000 fits: no borrow leaves the last product bit
	`FIRM_ASSERT_NOW(a_prod_exact, ser_en && (bit_q == PROD_LAST), p_br_n == 2'd0)
	// a finished division hands straight to the result stage
	`FIRM_ASSERT_NEXT(a_div_to_done, div_stat.done, state_q == ST_DONE)
	// a result appears only out of the result stage
	`FIRM_ASSERT_NOW(a_result_from_done, $rose(results.valid), $past(state_q == ST_DONE))

endmodule
`default_nettype wire

>>> tb/frame_interval_rate_meter_test.sv
// Self-checking testbench of the frame interval rate meter: timing prediction and result checks.
`timescale 1ns / 100ps
module frame_interval_rate_meter_test;
	import firm_pkg::*;

	// Cycles without any transaction before the run is declared hung. The limit covers a mark
	// that closes a window, the longest sender gap and receiver stall, and the settle pause
	// before a register write, several times over.
	localparam int WATCHDOG_LIMIT = 3000;
	// Cycles to let pass once nothing is expected any more (slowest transaction plus margin).
	localparam int SETTLE_CYCLES  = 150;

	// One result of the meter, field by field.
	typedef struct packed {
		logic [WORD_W-1:0] frame_time;
		logic [WORD_W-1:0] window_span;
		logic [SUM_W-1:0]  span_sum;
		logic [WORD_W-1:0] frame_count;
		logic [WORD_W-1:0] long_rate;
		logic              rate_updated;
		logic              time_held;
	} meter_readout_t;

	// Tracks the meter's timing state, works out the readout of every accepted event and
	// compares the block's readouts against them in order.
	class meter_scoreboard;
		logic [LW_W-1:0]    window_len;
		logic [GUESS_W-1:0] seed_step;
		logic [WORD_W-1:0]  newest_clock;
		logic [WORD_W-1:0]  prev_mark;
		logic [WORD_W-1:0]  history [HIST_DEPTH];
		logic [WORD_W-1:0]  frames;
		logic [WORD_W-1:0]  window_count;
		logic [WORD_W-1:0]  deadline;
		logic [WORD_W-1:0]  rate;
		logic [SUM_W-1:0]   span_acc;
		meter_readout_t     expected_readouts [$];
		int errors;
		int events_seen;
		int starts_seen;
		int held_seen;
		int closes_seen;
		int results_seen;

		function new();
			window_len   = LW_RESET;
			seed_step    = GUESS_RESET;
			newest_clock = '0;
			prev_mark    = '0;
			foreach (history[i])
				history[i] = '0;
			frames       = '0;
			window_count = '0;
			deadline     = '0;
			rate         = '0;
			span_acc     = '0;
			errors       = 0;
			events_seen  = 0;
			starts_seen  = 0;
			held_seen    = 0;
			closes_seen  = 0;
			results_seen = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_LONG_WINDOW: window_len = data[LW_W-1:0];
				CFG_START_GUESS: seed_step = data[GUESS_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the timing state by one accepted event and queue its readout.
		function void note_event(logic act, logic [WORD_W-1:0] raw);
			meter_readout_t    e;
			logic [WORD_W-1:0] t;
			logic [WORD_W-1:0] seed;
			logic [WORD_W-1:0] late_ms;
			logic [SUM_W:0]    acc;
			longint unsigned   elapsed;
			longint unsigned   num;
			longint unsigned   q;
			e = '0;
			events_seen++;
			// Never let time run backwards: hold the newest reading seen so far.
			if (raw < newest_clock) begin
				t = newest_clock;
				e.time_held = 1'b1;
				held_seen++;
			end else begin
				t = raw;
				newest_clock = raw;
			end
			if (act == ACT_START) begin
				starts_seen++;
				prev_mark = t;
				// Seed the history with marks spaced one guessed interval apart, newest on top.
				seed = t;
				for (int k = 0; k < HIST_DEPTH; k++) begin
					seed = seed - WORD_W'(seed_step);
					history[HIST_DEPTH-1-k] = seed;
				end
				frames       = '0;
				window_count = '0;
				rate         = '0;
				span_acc     = '0;
				deadline     = t + WORD_W'(window_len);
			end else begin
				for (int i = 0; i < HIST_DEPTH - 1; i++)
					history[i] = history[i+1];
				history[HIST_DEPTH-1] = prev_mark;
				prev_mark = t;
				e.frame_time  = t - history[HIST_DEPTH-1];
				e.window_span = t - history[0];
				// Saturate the running span sum at all ones.
				acc = {1'b0, span_acc} + (SUM_W+1)'(e.window_span);
				span_acc = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
				frames++;
				window_count++;
				if (t > deadline) begin
					late_ms = t - deadline;
					elapsed = {32'd0, late_ms} + {48'd0, window_len};
					num     = {32'd0, window_count} * 64'd1000;
					num     = num << RATE_FRAC;
					q       = num / elapsed;
					rate    = (q > 64'h0000_0000_FFFF_FFFF) ? '1 : q[WORD_W-1:0];
					window_count = '0;
					deadline     = t + WORD_W'(window_len);
					e.rate_updated = 1'b1;
					closes_seen++;
				end
				e.span_sum    = span_acc;
				e.frame_count = frames;
				e.long_rate   = rate;
			end
			expected_readouts.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH at result %0d: %s", results_seen, msg);
			errors++;
		endtask

		task compare(string name, longint unsigned got, longint unsigned want);
			if (got != want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check_result(meter_readout_t got);
			meter_readout_t want;
			results_seen++;
			if (expected_readouts.size() == 0) begin
				report("readout with no event waiting for it");
				return;
			end
			want = expected_readouts.pop_front();
			compare("frame_time_ms", got.frame_time, want.frame_time);
			compare("window_span_ms", got.window_span, want.window_span);
			compare("span_sum", got.span_sum, want.span_sum);
			compare("frame_count", got.frame_count, want.frame_count);
			compare("long_rate_q8", got.long_rate, want.long_rate);
			compare("rate_updated", got.rate_updated, want.rate_updated);
			compare("time_held", got.time_held, want.time_held);
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	firm_in_if  evt ();
	firm_out_if rdout ();

	frame_interval_rate_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (evt),
		.results   (rdout),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	meter_scoreboard sb = new();

	logic [WORD_W-1:0] now_ms;        // sender's notion of the current clock reading
	bit                tx_steady;     // phase with no sender gaps
	bit                rx_steady;     // phase with no receiver stalls
	int                settings_used;
	int                quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones; none during a steady stretch.
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Move the clock forward, pinning it at the top of the 32-bit range.
	function automatic logic [WORD_W-1:0] advance(logic [WORD_W-1:0] base, int unsigned d);
		if (base > 32'hFFFF_FFFF - d)
			return '1;
		return base + d;
	endfunction

	// Offer one event, hold it until accepted, then idle for a random gap.
	task automatic push_event(logic act, logic [WORD_W-1:0] raw);
		int gap;
		evt.valid    <= 1'b1;
		evt.action   <= act;
		evt.clock_ms <= raw;
		do
			@(posedge clk);
		while (!evt.ready);
		sb.note_event(act, raw);
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			evt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	// Drain the block, then load both registers and pick the idling style of the next phase.
	task automatic set_config(logic [CFG_W-1:0] win_data, logic [CFG_W-1:0] guess_data);
		evt.valid <= 1'b0;
		while (sb.expected_readouts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(CFG_LONG_WINDOW, win_data);
		write_register(CFG_START_GUESS, guess_data);
		settings_used++;
		tx_steady = ($urandom_range(0, 4) == 0);
		rx_steady = ($urandom_range(0, 4) == 0);
	endtask

	// Open with a start, then mostly well-formed marks with random spacing, mixed with
	// equal readings, backward readings, restarts and long jumps past the window.
	task automatic random_items(int count, int unsigned win, int unsigned step_max);
		int               r;
		logic [WORD_W-1:0] raw;
		logic             act;
		push_event(ACT_START, now_ms);
		for (int n = 1; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				now_ms = advance(now_ms, $urandom_range(0, step_max));
				push_event(ACT_START, now_ms);
			end else if (r < 9) begin
				raw = (now_ms == 0) ? '0 : WORD_W'($urandom_range(0, now_ms - 1));
				act = ($urandom_range(0, 7) == 0) ? ACT_START : ACT_MARK;
				push_event(act, raw);
			end else if (r < 13) begin
				push_event(ACT_MARK, now_ms);
			end else if (r < 15) begin
				now_ms = advance(now_ms, $urandom_range(1, 4 * win + 8));
				push_event(ACT_MARK, now_ms);
			end else begin
				now_ms = advance(now_ms, $urandom_range(1, step_max));
				push_event(ACT_MARK, now_ms);
			end
		end
	endtask

	// Receiver: check each readout at the edge that takes it, then stall at random.
	initial begin
		meter_readout_t got;
		int             rx_hold;
		rdout.ready <= 1'b0;
		rx_hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rdout.valid && rdout.ready) begin
				got.frame_time   = rdout.frame_time_ms;
				got.window_span  = rdout.window_span_ms;
				got.span_sum     = rdout.span_sum;
				got.frame_count  = rdout.frame_count;
				got.long_rate    = rdout.long_rate_q8;
				got.rate_updated = rdout.rate_updated;
				got.time_held    = rdout.time_held;
				sb.check_result(got);
				rx_hold = pick_gap(rx_steady);
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			rdout.ready <= (rx_hold == 0);
		end
	end

	// Watchdog: end the run when no transaction happens for too long.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((evt.valid && evt.ready) || (rdout.valid && rdout.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("frame_interval_rate_meter test failed");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= CFG_LONG_WINDOW;
		cfg_data     <= '0;
		evt.valid    <= 1'b0;
		evt.action   <= ACT_START;
		evt.clock_ms <= '0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		settings_used = 0;
		now_ms        = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: marks on the reset state, a start whose seeded history wraps below zero,
		// equal and backward readings, a window close, and a held start.
		push_event(ACT_MARK, 32'd0);
		push_event(ACT_MARK, 32'd7);
		push_event(ACT_START, 32'd12);
		push_event(ACT_MARK, 32'd40);
		push_event(ACT_MARK, 32'd40);
		push_event(ACT_MARK, 32'd25);
		push_event(ACT_MARK, 32'd600);
		push_event(ACT_MARK, 32'd601);
		push_event(ACT_START, 32'd100);
		// Shortest nonzero window, zero guess.
		set_config(16'd1, 16'd0);
		push_event(ACT_START, 32'd700);
		push_event(ACT_MARK, 32'd700);
		push_event(ACT_MARK, 32'd701);
		push_event(ACT_MARK, 32'd702);
		push_event(ACT_MARK, 32'd5000);
		// Zero-length window, guess register written with all ones (largest guess).
		set_config(16'd0, 16'hFFFF);
		push_event(ACT_START, 32'd5000);
		push_event(ACT_MARK, 32'd5001);
		push_event(ACT_MARK, 32'd5001);
		push_event(ACT_MARK, 32'd6003);
		// Longest window.
		set_config(16'hFFFF, 16'd1000);
		push_event(ACT_START, 32'd6100);
		push_event(ACT_MARK, 32'd6130);
		push_event(ACT_MARK, 32'd80000);
		push_event(ACT_MARK, 32'd200000);
		now_ms = 32'd200000;

		// Random phases over several register settings, extremes included.
		set_config(LW_RESET, GUESS_RESET);
		random_items(300, 500, 40);
		set_config(16'd1, 16'd0);
		random_items(200, 1, 3);
		set_config(16'hFFFF, {6'($urandom), 10'd1023});
		random_items(200, 65535, 8000);
		set_config(16'd0, 16'd1000);
		random_items(150, 0, 3);
		for (int p = 0; p < 3; p++) begin
			int unsigned win;
			win = $urandom_range(1, 65535);
			set_config(CFG_W'(win), CFG_W'($urandom));
			random_items(150, win, win / 6 + 1);
		end

		// Top of the clock range: deadlines and seeded history wrap, readings pin at all ones.
		set_config(LW_RESET, GUESS_RESET);
		now_ms = 32'hFFFF_F000;
		random_items(200, 500, 40);
		push_event(ACT_MARK, 32'hFFFF_FFFF);
		push_event(ACT_START, 32'hFFFF_FFFF);
		push_event(ACT_MARK, 32'hFFFF_FFFF);
		push_event(ACT_START, 32'd0);
		push_event(ACT_MARK, 32'd0);

		// Drain and let the block settle.
		evt.valid <= 1'b0;
		while (sb.expected_readouts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d events: %0d starts, %0d held readings, %0d rate windows closed",
			sb.events_seen, sb.starts_seen, sb.held_seen, sb.closes_seen);
		$display("checked %0d readouts over %0d register settings, %0d mismatches",
			sb.results_seen, settings_used, sb.errors);
		if (sb.errors == 0)
			$display("frame_interval_rate_meter test passed");
		else
			$display("frame_interval_rate_meter test failed");
		$finish;
	end

endmodule
